@@ design/gcd_pkg.sv @@
package gcd_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int RAD_STAGES = 4;

	// Angle scaling: pi * 2^31, and the full, half and quarter turn in 1e-7 degree
	localparam logic [33:0] PI31 = 34'd6746518852;
	localparam logic [33:0] TURN_UNITS = 34'd3600000000;
	localparam logic [33:0] TURN2_UNITS = 34'd7200000000;
	localparam logic signed [34:0] TURN_S = 35'sd3600000000;
	localparam logic signed [34:0] HALF_TURN_S = 35'sd1800000000;
	localparam logic [30:0] HALF_TURN = 31'd1800000000;
	localparam logic [30:0] QUARTER_TURN = 31'd900000000;

	// floor(PI31 * 2^32 / TURN_UNITS); serves both divisors with a shift of 32 or 33
	localparam logic [66:0] RAD_RECIP_X = (67'(PI31) << 32) / 67'(TURN_UNITS);
	localparam logic [33:0] RAD_RECIP = 34'(RAD_RECIP_X);

	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [60:0] ONE_Q60 = 61'd1 << 60;
	localparam logic [30:0] RADIUS_X200_RST = 31'd1274200000;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

endpackage

@@ design/gcd_prep.sv @@
module gcd_prep (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_i,
	input  logic [30:0] lat_a,
	input  logic [31:0] lon_a,
	input  logic [30:0] lat_b,
	input  logic [31:0] lon_b,
	output logic        v_o,
	output logic [30:0] dlat_mag,
	output logic [30:0] dlon_mag,
	output logic [30:0] la_mag,
	output logic [30:0] lb_mag,
	output logic        neg
);
	import gcd_pkg::*;

	logic               v_s1, v_s2;
	logic signed [34:0] dlat_s1, dlon_s1;
	logic [30:0]        la_abs_s1, lb_abs_s1;
	logic [30:0]        dlat_s2, dlon_s2, la_s2, lb_s2;
	logic               neg_s2;
	logic signed [34:0] dlat_r, dlon_r;
	logic               na, nb;

	function automatic logic signed [34:0] wrap_turn(input logic signed [34:0] d);
		logic signed [34:0] r;
		if (d >= HALF_TURN_S) begin
			r = d - TURN_S;
		end else if (d < -HALF_TURN_S) begin
			r = d + TURN_S;
		end else begin
			r = d;
		end
		return r;
	endfunction

	always_comb begin
		dlat_r = wrap_turn(dlat_s1);
		dlon_r = wrap_turn(dlon_s1);
		na = la_abs_s1 > QUARTER_TURN;
		nb = lb_abs_s1 > QUARTER_TURN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 35'($signed(lat_b)) - 35'($signed(lat_a));
			dlon_s1 <= 35'($signed(lon_b)) - 35'($signed(lon_a));
			la_abs_s1 <= lat_a[30] ? (~lat_a + 31'd1) : lat_a;
			lb_abs_s1 <= lat_b[30] ? (~lat_b + 31'd1) : lat_b;
			dlat_s2 <= dlat_r[34] ? 31'(-dlat_r) : 31'(dlat_r);
			dlon_s2 <= dlon_r[34] ? 31'(-dlon_r) : 31'(dlon_r);
			// past the pole: fold to 180 - m, cosine changes sign
			la_s2 <= na ? (HALF_TURN - la_abs_s1) : la_abs_s1;
			lb_s2 <= nb ? (HALF_TURN - lb_abs_s1) : lb_abs_s1;
			neg_s2 <= na ^ nb;
		end
	end

	assign v_o = v_s2;
	assign dlat_mag = dlat_s2;
	assign dlon_mag = dlon_s2;
	assign la_mag = la_s2;
	assign lb_mag = lb_s2;
	assign neg = neg_s2;

endmodule

@@ design/gcd_rad.sv @@
module gcd_rad #(
	parameter bit HALF = 1'b0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_i,
	input  logic [30:0] mag_i,
	output logic        v_o,
	output logic [30:0] ang_o
);
	import gcd_pkg::*;

	localparam int SH = HALF ? 33 : 32;
	localparam logic [64:0] DIV = HALF ? 65'(TURN2_UNITS) : 65'(TURN_UNITS);
	localparam logic [64:0] RND = 65'd1 << (SH - 1);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [64:0] est_p_s1, num_s1, num_s2, num_s3, ediv_s3;
	logic [30:0] est_s2, est_s3, ang_s4;
	logic [64:0] rem;
	logic [64:0] est_sum;

	// estimate never exceeds the rounded quotient and is at most one below it
	assign est_sum = est_p_s1 + RND;
	assign rem = num_s3 + (DIV >> 1) - ediv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			est_p_s1 <= 65'(mag_i) * 65'(RAD_RECIP);
			num_s1 <= 65'(mag_i) * 65'(PI31);
			est_s2 <= 31'(est_sum >> SH);
			num_s2 <= num_s1;
			ediv_s3 <= 65'(est_s2) * DIV;
			est_s3 <= est_s2;
			num_s3 <= num_s2;
			ang_s4 <= est_s3 + 31'(rem >= DIV);
		end
	end

	assign v_o = v_s4;
	assign ang_o = ang_s4;

endmodule

@@ design/gcd_cordic.sv @@
module gcd_cordic #(
	parameter int STEPS = 24,
	parameter bit VECTOR = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_i,
	input  logic signed [33:0] x_i,
	input  logic signed [33:0] y_i,
	input  logic signed [33:0] z_i,
	output logic               v_o,
	output logic [30:0]        x_o,
	output logic [30:0]        y_o,
	output logic [30:0]        z_o
);
	import gcd_pkg::*;

	logic signed [33:0] x_s [STEPS];
	logic signed [33:0] y_s [STEPS];
	logic signed [33:0] z_s [STEPS];
	logic               v_s [STEPS];
	logic               v_c_q;
	logic [30:0]        x_c_q, y_c_q, z_c_q;
	logic signed [33:0] xl, yl, zl;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [33:0] xp, yp, zp, at;
		logic               vp, dn;
		if (i == 0) begin : g_first
			assign xp = x_i;
			assign yp = y_i;
			assign zp = z_i;
			assign vp = v_i;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
		end
		assign at = 34'(ATAN_Q30[i]);
		// rotation drives z to zero, vectoring drives y to zero
		assign dn = VECTOR ? yp[33] : ~zp[33];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (dn) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - at;
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + at;
				end
			end
		end
	end

	assign xl = x_s[STEPS-1];
	assign yl = y_s[STEPS-1];
	assign zl = z_s[STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c_q <= 1'b0;
		end else if (en) begin
			v_c_q <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_c_q <= xl[33] ? 31'd0 : (xl > ONE_Q30 ? 31'(ONE_Q30) : 31'(xl));
			y_c_q <= yl[33] ? 31'd0 : (yl > ONE_Q30 ? 31'(ONE_Q30) : 31'(yl));
			z_c_q <= zl[33] ? 31'd0 : (zl > HALF_PI_Q30 ? 31'(HALF_PI_Q30) : 31'(zl));
		end
	end

	assign v_o = v_c_q;
	assign x_o = x_c_q;
	assign y_o = y_c_q;
	assign z_o = z_c_q;

endmodule

@@ design/gcd_sqrt.sv @@
module gcd_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_i,
	input  logic [60:0] n_i,
	output logic        v_o,
	output logic [30:0] root_o
);
	import gcd_pkg::*;

	logic [63:0] n_s [SQRT_STEPS];
	logic [63:0] r_s [SQRT_STEPS];
	logic        v_s [SQRT_STEPS];

	// restoring square root, one result bit per stage
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [63:0] np, rp, bitv, trial;
		logic        vp;
		if (i == 0) begin : g_first
			assign np = 64'(n_i);
			assign rp = 64'd0;
			assign vp = v_i;
		end else begin : g_next
			assign np = n_s[i-1];
			assign rp = r_s[i-1];
			assign vp = v_s[i-1];
		end
		assign bitv = 64'd1 << (62 - 2 * i);
		assign trial = rp + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (np >= trial) begin
					n_s[i] <= np - trial;
					r_s[i] <= (rp >> 1) + bitv;
				end else begin
					n_s[i] <= np;
					r_s[i] <= rp >> 1;
				end
			end
		end
	end

	assign v_o = v_s[SQRT_STEPS-1];
	assign root_o = r_s[SQRT_STEPS-1][30:0];

endmodule

@@ design/great_circle_distance_top.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    lat_a, lon_a, lat_b, lon_b
// out       output     out_valid/out_ready  distance_cm
// cfg       input      cfg_valid/cfg_ready  earth_radius_m
//
// One item per cycle while not stalled; the pipe runs through the
// two CORDIC chains and the 32-stage square roots, one iteration per stage.
// Reset clears valid bits and loads the radius register with 6371000 m.
// Stalls freeze the whole pipe: in_ready = out_ready | ~out_valid.
// cfg_ready is always high; the scaled radius is used at the last multiply.
module great_circle_distance_top #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] lat_a,
	input  logic [31:0] lon_a,
	input  logic [30:0] lat_b,
	input  logic [31:0] lon_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] distance_cm,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [22:0] earth_radius_m
);
	import gcd_pkg::*;

	localparam int NEG_DLY = RAD_STAGES + CORDIC_STEPS + 1;

	logic        en;
	logic        pv, rv, cv, qv, av;
	logic [30:0] dlat_mag, dlon_mag, la_mag, lb_mag;
	logic        neg_p;
	logic [30:0] ang_dlat, ang_dlon, ang_la, ang_lb;
	logic [30:0] s1, s2, ca, cb;
	logic [30:0] ry, rx, ang;
	logic        neg_dly [NEG_DLY];
	logic [30:0] radius_x200_q;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [30:0] cc_s1, s2_s1, t1_s2, s2_s2;
	logic [60:0] s1sq_s1, s1sq_s2, s1sq_s3, term_s3, a_s4, b_s4;
	logic        neg_s1, neg_s2, neg_s3;
	logic [61:0] prod_cc;
	logic [61:0] prod_t1;
	logic [62:0] dist_p_s5;
	logic [31:0] dist_s6;
	logic signed [62:0] hav_sum;
	logic [60:0] hav_a;
	logic [62:0] dist_rnd;

	assign en = out_ready | ~v_s6;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x200_q <= RADIUS_X200_RST;
		end else if (cfg_valid) begin
			radius_x200_q <= 31'(earth_radius_m) * 31'd200;
		end
	end

	gcd_prep u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(in_valid & in_ready),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.v_o(pv), .dlat_mag(dlat_mag), .dlon_mag(dlon_mag),
		.la_mag(la_mag), .lb_mag(lb_mag), .neg(neg_p)
	);

	gcd_rad #(.HALF(1'b1)) u_rad_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(pv), .mag_i(dlat_mag),
		.v_o(rv), .ang_o(ang_dlat)
	);
	gcd_rad #(.HALF(1'b1)) u_rad_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(pv), .mag_i(dlon_mag),
		.v_o(), .ang_o(ang_dlon)
	);
	gcd_rad #(.HALF(1'b0)) u_rad_la (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(pv), .mag_i(la_mag),
		.v_o(), .ang_o(ang_la)
	);
	gcd_rad #(.HALF(1'b0)) u_rad_lb (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(pv), .mag_i(lb_mag),
		.v_o(), .ang_o(ang_lb)
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv),
		.x_i(GAIN_Q30), .y_i(34'sd0), .z_i(34'(ang_dlat)),
		.v_o(cv), .x_o(), .y_o(s1), .z_o()
	);
	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv),
		.x_i(GAIN_Q30), .y_i(34'sd0), .z_i(34'(ang_dlon)),
		.v_o(), .x_o(), .y_o(s2), .z_o()
	);
	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_la (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv),
		.x_i(GAIN_Q30), .y_i(34'sd0), .z_i(34'(ang_la)),
		.v_o(), .x_o(ca), .y_o(), .z_o()
	);
	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_lb (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv),
		.x_i(GAIN_Q30), .y_i(34'sd0), .z_i(34'(ang_lb)),
		.v_o(), .x_o(cb), .y_o(), .z_o()
	);

	// cosine-sign flag rides alongside the conversion and rotation stages
	always_ff @(posedge clk) begin
		if (en) begin
			neg_dly[0] <= neg_p;
			for (int k = 1; k < NEG_DLY; k++) begin
				neg_dly[k] <= neg_dly[k-1];
			end
		end
	end

	assign prod_cc = 62'(ca) * 62'(cb);
	assign prod_t1 = 62'(cc_s1) * 62'(s2_s1);

	always_comb begin
		if (neg_s3) begin
			hav_sum = $signed(63'(s1sq_s3) - 63'(term_s3));
		end else begin
			hav_sum = $signed(63'(s1sq_s3) + 63'(term_s3));
		end
		if (hav_sum[62]) begin
			hav_a = 61'd0;
		end else if (hav_sum[61:0] > 62'(ONE_Q60)) begin
			hav_a = ONE_Q60;
		end else begin
			hav_a = hav_sum[60:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= cv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= av;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= prod_cc[60:30];
			s1sq_s1 <= 61'(62'(s1) * 62'(s1));
			s2_s1 <= s2;
			neg_s1 <= neg_dly[NEG_DLY-1];
			t1_s2 <= prod_t1[60:30];
			s2_s2 <= s2_s1;
			s1sq_s2 <= s1sq_s1;
			neg_s2 <= neg_s1;
			term_s3 <= 61'(62'(t1_s2) * 62'(s2_s2));
			s1sq_s3 <= s1sq_s2;
			neg_s3 <= neg_s2;
			a_s4 <= hav_a;
			b_s4 <= ONE_Q60 - hav_a;
		end
	end

	gcd_sqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s4), .n_i(a_s4),
		.v_o(qv), .root_o(ry)
	);
	gcd_sqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s4), .n_i(b_s4),
		.v_o(), .root_o(rx)
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(qv),
		.x_i(34'(rx)), .y_i(34'(ry)), .z_i(34'sd0),
		.v_o(av), .x_o(), .y_o(), .z_o(ang)
	);

	assign dist_rnd = dist_p_s5 + (63'd1 << 29);

	// radius_x200_q already holds the factor 2 of the central angle
	always_ff @(posedge clk) begin
		if (en) begin
			dist_p_s5 <= 63'(radius_x200_q) * 63'(ang);
			dist_s6 <= dist_rnd[61:30];
		end
	end

	assign out_valid = v_s6;
	assign distance_cm = dist_s6;

endmodule

@@ design/gcd_chk.sv @@
module gcd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [30:0] lat_a,
	input logic [31:0] lon_a,
	input logic [30:0] lat_b,
	input logic [31:0] lon_b,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] distance_cm
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(lat_a) && $stable(lon_a)
			&& $stable(lat_b) && $stable(lon_b))
		else $error("input item changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_cm))
		else $error("result changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("input ready does not follow output stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_cm <= 32'd2636000000)
		else $error("distance beyond half circumference of largest radius");

endmodule

bind great_circle_distance_top gcd_chk u_gcd_chk (.*);
